@@ rtl/core/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, compiled out for synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define TST_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
`define TST_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) (prop)) \
      else $error("assertion failed");
`else
`define TST_ASSERT(label, clk, rst, prop)
`define TST_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

@@ rtl/core/tst_pkg.sv @@
// ---------------------------------------------------------------------------
// tst_pkg
// Shared types and constants of the transfer session table.
// ---------------------------------------------------------------------------
`default_nettype none

package tst_pkg;

   localparam int unsigned TABLE_ENTRIES   = 8;
   localparam logic [31:0] TOP_BIT         = 32'h8000_0000;
   localparam logic [31:0] DEFAULT_TIMEOUT = 32'd60000;

   typedef enum logic [1:0] {
      MODE_ALLOC   = 2'd0,
      MODE_FIND    = 2'd1,
      MODE_ADVANCE = 2'd2,
      MODE_FREE    = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_FULL    = 2'd1,
      ST_MISSING = 2'd2
   } status_type;

   // request word walking the cell chain, with the answer gathered so far
   typedef struct packed {
      logic        valid;
      mode_type    mode;
      logic [31:0] now_ms;
      logic [31:0] record_id;
      logic [31:0] transfer_handle;
      logic [15:0] new_offset;
      logic [31:0] deadline;
      logic [31:0] new_handle;
      logic        done;
      logic [31:0] handle_out;
      logic [31:0] record_out;
      logic [15:0] offset_out;
   } token_type;

endpackage

`default_nettype wire

@@ rtl/core/tst_req_if.sv @@
// ---------------------------------------------------------------------------
// tst_req_if
// Request channel: one session command word.
// ---------------------------------------------------------------------------
`default_nettype none

interface tst_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  mode;
   logic [31:0] now_ms;
   logic [31:0] record_id;
   logic [31:0] transfer_handle;
   logic [15:0] new_offset;

   modport source (output valid, mode, now_ms, record_id, transfer_handle, new_offset,
                   input ready);
   modport sink   (input valid, mode, now_ms, record_id, transfer_handle, new_offset,
                   output ready);
endinterface

`default_nettype wire

@@ rtl/core/tst_rsp_if.sv @@
// ---------------------------------------------------------------------------
// tst_rsp_if
// Response channel: one result word per request.
// ---------------------------------------------------------------------------
`default_nettype none

interface tst_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [31:0] handle_out;
   logic [31:0] record_out;
   logic [15:0] offset_out;

   modport source (output valid, status, handle_out, record_out, offset_out, input ready);
   modport sink   (input valid, status, handle_out, record_out, offset_out, output ready);
endinterface

`default_nettype wire

@@ rtl/core/tst_csr_if.sv @@
// ---------------------------------------------------------------------------
// tst_csr_if
// Register write channel carrying the session timeout.
// ---------------------------------------------------------------------------
`default_nettype none

interface tst_csr_if;
   logic        valid;
   logic        ready;
   logic [31:0] timeout_ms;

   modport source (output valid, timeout_ms, input ready);
   modport sink   (input valid, timeout_ms, output ready);
endinterface

`default_nettype wire

@@ rtl/core/tst_cell.sv @@
// ---------------------------------------------------------------------------
// tst_cell
// One table entry: retires on expiry, claims or matches the passing word.
// ---------------------------------------------------------------------------
`default_nettype none

module tst_cell (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire tst_pkg::token_type tok_in,
   output      tst_pkg::token_type tok_out
);
   import tst_pkg::*;

   logic        valid_ff,    valid_in;
   logic [31:0] handle_ff,   handle_in;
   logic [31:0] record_ff,   record_in;
   logic [15:0] offset_ff,   offset_in;
   logic [31:0] deadline_ff, deadline_in;
   token_type   tok_ff,      tok_nx;
   logic        tok_vld_ff;
   logic        expired;
   logic        live;

   always_comb begin
      expired     = valid_ff && (deadline_ff != 32'd0) && (deadline_ff <= tok_in.now_ms);
      live        = valid_ff && !(expired && (tok_in.mode != MODE_FREE));
      valid_in    = valid_ff;
      handle_in   = handle_ff;
      record_in   = record_ff;
      offset_in   = offset_ff;
      deadline_in = deadline_ff;
      tok_nx      = tok_in;
      if (tok_in.valid) begin
         valid_in = live;
         unique case (tok_in.mode)
            MODE_ALLOC: begin
               if (!tok_in.done && !live) begin
                  valid_in          = 1'b1;
                  handle_in         = tok_in.new_handle;
                  record_in         = tok_in.record_id;
                  offset_in         = 16'd0;
                  deadline_in       = tok_in.deadline;
                  tok_nx.done       = 1'b1;
                  tok_nx.handle_out = tok_in.new_handle;
                  tok_nx.record_out = tok_in.record_id;
                  tok_nx.offset_out = 16'd0;
               end
            end
            MODE_FIND, MODE_ADVANCE, MODE_FREE: begin
               if (!tok_in.done && live && (handle_ff == tok_in.transfer_handle)) begin
                  tok_nx.done       = 1'b1;
                  tok_nx.handle_out = handle_ff;
                  tok_nx.record_out = record_ff;
                  tok_nx.offset_out = offset_ff;
                  if (tok_in.mode == MODE_ADVANCE) begin
                     offset_in         = tok_in.new_offset;
                     deadline_in       = tok_in.deadline;
                     tok_nx.offset_out = tok_in.new_offset;
                  end
                  if (tok_in.mode == MODE_FREE) begin
                     valid_in = 1'b0;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= 1'b0;
         tok_vld_ff <= 1'b0;
      end else begin
         valid_ff   <= valid_in;
         tok_vld_ff <= tok_nx.valid;
      end
   end

   always_ff @(posedge clock) begin
      handle_ff   <= handle_in;
      record_ff   <= record_in;
      offset_ff   <= offset_in;
      deadline_ff <= deadline_in;
      tok_ff      <= tok_nx;
   end

   always_comb begin
      tok_out       = tok_ff;
      tok_out.valid = tok_vld_ff;
   end

endmodule

`default_nettype wire

@@ rtl/core/transfer_session_table.sv @@
// Path: the request word is registered in each of the TABLE_ENTRIES entry cells
// in turn and then in the response register. Flow: one request at a time; the
// request word walks the row of TABLE_ENTRIES entry cells, one cell per cycle,
// and a new request is accepted only once the response has been taken.
// Reset: all entries invalid, handle counter 1, timeout 60000, no word in flight.
// ---------------------------------------------------------------------------
// transfer_session_table
// Multipart-transfer session table built as a chain of entry cells.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module transfer_session_table (
   input  wire logic clock,
   input  wire logic reset,
   tst_req_if.sink   req_if,
   tst_rsp_if.source rsp_if,
   tst_csr_if.sink   csr_if
);
   import tst_pkg::*;

   logic        busy_ff,     busy_in;
   logic [31:0] cnt_ff,      cnt_in;
   logic [31:0] pend_cnt_ff, pend_cnt_in;
   logic [31:0] timeout_ff,  timeout_in;
   logic        rsp_vld_ff,  rsp_vld_in;
   logic [1:0]  status_ff,   status_in;
   logic [31:0] hout_ff,     hout_in;
   logic [31:0] rout_ff,     rout_in;
   logic [15:0] oout_ff,     oout_in;

   logic        req_acc;
   logic [31:0] cnt_next;
   token_type   chain [TABLE_ENTRIES+1];
   token_type   fin;
   logic [TABLE_ENTRIES:0] inflight;

   assign req_if.ready = !busy_ff;
   assign csr_if.ready = 1'b1;
   assign req_acc      = req_if.valid && !busy_ff;
   assign cnt_next     = (cnt_ff == 32'hFFFF_FFFF) ? 32'd1 : cnt_ff + 32'd1;

   always_comb begin
      chain[0].valid           = req_acc;
      chain[0].mode            = mode_type'(req_if.mode);
      chain[0].now_ms          = req_if.now_ms;
      chain[0].record_id       = req_if.record_id;
      chain[0].transfer_handle = req_if.transfer_handle;
      chain[0].new_offset      = req_if.new_offset;
      chain[0].deadline        = req_if.now_ms + timeout_ff;
      chain[0].new_handle      = cnt_next | TOP_BIT;
      chain[0].done            = 1'b0;
      chain[0].handle_out      = 32'd0;
      chain[0].record_out      = 32'd0;
      chain[0].offset_out      = 16'd0;
   end

   for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
      tst_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .tok_in  (chain[i]),
         .tok_out (chain[i+1])
      );
      assign inflight[i] = chain[i+1].valid;
   end
   assign inflight[TABLE_ENTRIES] = rsp_vld_ff;

   assign fin = chain[TABLE_ENTRIES];

   always_comb begin
      busy_in     = busy_ff;
      cnt_in      = cnt_ff;
      pend_cnt_in = pend_cnt_ff;
      timeout_in  = timeout_ff;
      rsp_vld_in  = rsp_vld_ff;
      status_in   = status_ff;
      hout_in     = hout_ff;
      rout_in     = rout_ff;
      oout_in     = oout_ff;
      if (csr_if.valid) begin
         timeout_in = csr_if.timeout_ms;
      end
      if (req_acc) begin
         busy_in     = 1'b1;
         pend_cnt_in = cnt_next;
      end
      if (rsp_vld_ff && rsp_if.ready) begin
         rsp_vld_in = 1'b0;
         busy_in    = 1'b0;
      end
      if (fin.valid) begin
         rsp_vld_in = 1'b1;
         hout_in    = fin.handle_out;
         rout_in    = fin.record_out;
         oout_in    = fin.offset_out;
         if (fin.done) begin
            status_in = ST_OK;
            if (fin.mode == MODE_ALLOC) begin
               cnt_in = pend_cnt_ff;
            end
         end else if (fin.mode == MODE_ALLOC) begin
            status_in = ST_FULL;
         end else begin
            status_in = ST_MISSING;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b0;
         cnt_ff     <= 32'd1;
         timeout_ff <= DEFAULT_TIMEOUT;
         rsp_vld_ff <= 1'b0;
      end else begin
         busy_ff    <= busy_in;
         cnt_ff     <= cnt_in;
         timeout_ff <= timeout_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_cnt_ff <= pend_cnt_in;
      status_ff   <= status_in;
      hout_ff     <= hout_in;
      rout_ff     <= rout_in;
      oout_ff     <= oout_in;
   end

   assign rsp_if.valid      = rsp_vld_ff;
   assign rsp_if.status     = status_ff;
   assign rsp_if.handle_out = hout_ff;
   assign rsp_if.record_out = rout_ff;
   assign rsp_if.offset_out = oout_ff;

   `TST_ASSERT(a_one_word, clock, reset, $onehot0(inflight))
   `TST_ASSERT(a_enter_chain, clock, reset, req_acc |=> chain[1].valid)
   `TST_ASSERT(a_busy_cover, clock, reset, (inflight != '0) |-> busy_ff)
   `TST_ASSERT(a_cnt_move, clock, reset,
      (cnt_ff != $past(cnt_ff)) |->
         ($past(reset) || ($past(fin.valid) && $past(fin.done) &&
          ($past(fin.mode) == MODE_ALLOC))))

endmodule

`default_nettype wire
